FILE: rtl/tkpis_pkg.sv
// ----------------------------------------------------------------------------
// Top-K priority index select package
// Shared types and constants for the top-K priority index selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tkpis_pkg;

    localparam int DATA_W              = 16;
    localparam int IDX_W               = 7;
    localparam int CFG_W               = 7;
    localparam int PICK_LIMIT          = 64;
    localparam int MAX_ENTRIES_DEFAULT = 64;
    localparam int NUM_PICKS_RESET     = 1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/tkpis_entry_ram.sv
// ----------------------------------------------------------------------------
// Top-K priority entry RAM
// Single write port, single registered read port storage for the entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpis_entry_ram #(
    parameter int DEPTH  = tkpis_pkg::MAX_ENTRIES_DEFAULT + 1,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int WORD_W = tkpis_pkg::DATA_W + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WORD_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/top_k_priority_index_select.sv
// ----------------------------------------------------------------------------
// Top-K priority index select
// Loads a vector of signed Q4.12 priorities and emits the indices of the
// largest entries, one argmax pass per index.
// ----------------------------------------------------------------------------
// Entries load at one transaction per cycle. After the transaction with tlast
// set, the input stalls while the block makes num_picks passes, capped at
// PICK_LIMIT, over the stored vector with one RAM read port and one signed
// comparator, reading one entry per cycle; a one-entry vector needs no pass.
// Each result is the index of the largest unused entry at position 1 or
// above, ties going to the lower index; position 0 is stored but never
// chosen, and a pick with no candidate left returns index 1.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_priority_index_select #(
    parameter int MAX_ENTRIES = tkpis_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tkpis_pkg::CFG_W-1:0]    i_cfg_data,     // num_picks
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [tkpis_pkg::DATA_W-1:0]   i_s_axis_tdata, // priority_value
    input  wire logic                           i_s_axis_tlast, // vector_end
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [7:0]                          o_m_axis_tdata, // chosen_index
    output logic                                o_m_axis_tlast  // final_pick
);

    localparam int SLOTS  = MAX_ENTRIES + 1;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = tkpis_pkg::DATA_W + 1;
    localparam int EXT_W  = ADDR_W + tkpis_pkg::IDX_W;
    localparam int PIK_W  = tkpis_pkg::IDX_W;

    localparam logic [CNT_W-1:0] SlotsC = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] OneC   = CNT_W'(1);
    localparam logic [PIK_W-1:0] LimitC = PIK_W'(tkpis_pkg::PICK_LIMIT);

    tkpis_pkg::t_state r_state;
    tkpis_pkg::t_state n_state;

    logic [tkpis_pkg::CFG_W-1:0]  r_num_picks;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             r_len;
    logic [PIK_W-1:0]             r_picks;
    logic [PIK_W-1:0]             r_pick_cnt;
    logic [ADDR_W-1:0]            r_addr;
    logic                         r_rd_vld;
    logic [ADDR_W-1:0]            r_rd_idx;
    logic                         r_found;
    logic [ADDR_W-1:0]            r_best;
    logic [tkpis_pkg::DATA_W-1:0] r_best_val;
    logic                         r_out_valid;
    logic [tkpis_pkg::IDX_W-1:0]  r_out_idx;
    logic                         r_out_last;

    logic                         w_in_acc;
    logic                         w_out_free;
    logic [CNT_W-1:0]             w_cnt_next;
    logic [PIK_W-1:0]             w_picks_sat;
    logic                         w_issue;
    logic                         w_last_issue;
    logic                         w_emit;
    logic                         w_last_pick;
    logic                         w_better;
    logic [EXT_W-1:0]             w_best_ext;
    logic                         w_ram_we;
    logic [ADDR_W-1:0]            w_ram_waddr;
    logic [WORD_W-1:0]            w_ram_wdata;
    logic [WORD_W-1:0]            w_ram_rdata;
    logic                         w_rd_used;
    logic [tkpis_pkg::DATA_W-1:0] w_rd_val;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == tkpis_pkg::ST_LOAD);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_idx};
    assign o_m_axis_tlast  = r_out_last;

    assign w_in_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free   = !r_out_valid || i_m_axis_tready;
    assign w_cnt_next   = (r_count < SlotsC) ? r_count + OneC : r_count;
    assign w_picks_sat  = (r_num_picks > LimitC) ? LimitC : r_num_picks;
    assign w_issue      = (r_state == tkpis_pkg::ST_SCAN);
    assign w_last_issue = w_issue && (CNT_W'(r_addr) == r_len - OneC);
    assign w_emit       = (r_state == tkpis_pkg::ST_FINISH) && w_out_free;
    assign w_last_pick  = (r_pick_cnt + PIK_W'(1)) == r_picks;
    assign w_best_ext   = EXT_W'(r_best);

    assign w_rd_used = w_ram_rdata[WORD_W-1];
    assign w_rd_val  = w_ram_rdata[tkpis_pkg::DATA_W-1:0];
    assign w_better  = r_rd_vld && !w_rd_used &&
                       (!r_found || ($signed(w_rd_val) > $signed(r_best_val)));

    assign w_ram_we    = (w_in_acc && (r_count < SlotsC)) || (w_emit && r_found);
    assign w_ram_waddr = (r_state == tkpis_pkg::ST_FINISH) ? r_best
                                                            : r_count[ADDR_W-1:0];
    assign w_ram_wdata = (r_state == tkpis_pkg::ST_FINISH) ? {1'b1, r_best_val}
                                                            : {1'b0, i_s_axis_tdata};

    tkpis_entry_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W),
        .WORD_W (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tkpis_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tkpis_pkg::ST_LOAD: begin
                if (w_in_acc && i_s_axis_tlast && (w_picks_sat != '0)) begin
                    if (w_cnt_next <= OneC) begin
                        n_state = tkpis_pkg::ST_FINISH;
                    end else begin
                        n_state = tkpis_pkg::ST_SCAN;
                    end
                end
            end
            tkpis_pkg::ST_SCAN: begin
                if (w_last_issue) begin
                    n_state = tkpis_pkg::ST_DRAIN;
                end
            end
            tkpis_pkg::ST_DRAIN: begin
                n_state = tkpis_pkg::ST_FINISH;
            end
            tkpis_pkg::ST_FINISH: begin
                if (w_emit) begin
                    priority if (w_last_pick) begin
                        n_state = tkpis_pkg::ST_LOAD;
                    end else if (r_len <= OneC) begin
                        n_state = tkpis_pkg::ST_FINISH;
                    end else begin
                        n_state = tkpis_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = tkpis_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_picks <= tkpis_pkg::CFG_W'(tkpis_pkg::NUM_PICKS_RESET);
            r_count     <= '0;
            r_len       <= '0;
            r_picks     <= '0;
            r_pick_cnt  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_num_picks <= i_cfg_data;
            end
            if (w_in_acc) begin
                if (i_s_axis_tlast) begin
                    r_count    <= '0;
                    r_len      <= w_cnt_next;
                    r_picks    <= w_picks_sat;
                    r_pick_cnt <= '0;
                end else begin
                    r_count <= w_cnt_next;
                end
            end
            r_rd_vld <= w_issue;
            if (w_emit) begin
                r_pick_cnt  <= r_pick_cnt + PIK_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (w_in_acc || w_emit) begin
            r_addr  <= ADDR_W'(1);
            r_found <= 1'b0;
            r_best  <= ADDR_W'(1);
        end else begin
            if (w_issue) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            if (w_better) begin
                r_found    <= 1'b1;
                r_best     <= r_rd_idx;
                r_best_val <= w_rd_val;
            end
        end
        if (w_emit) begin
            r_out_idx  <= w_best_ext[tkpis_pkg::IDX_W-1:0];
            r_out_last <= w_last_pick;
        end
    end

`ifndef SYNTH
    a_loss_slot_never_chosen: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tkpis_pkg::ST_FINISH && r_found) |-> (r_best != '0)
    ) else $error("loss slot selected as best entry");

    a_best_within_vector: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tkpis_pkg::ST_FINISH && r_found) |-> (CNT_W'(r_best) < r_len)
    ) else $error("best entry lies beyond the loaded vector");

    a_no_read_while_loading: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> !r_rd_vld
    ) else $error("input transaction accepted during a scan");

    a_pick_count_bounded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tkpis_pkg::ST_LOAD) |-> (r_pick_cnt < r_picks)
    ) else $error("pick counter ran past the requested number of picks");
`endif

endmodule

`default_nettype wire

FILE: tb/top_k_priority_index_select_tb.sv
// ----------------------------------------------------------------------------
// Top-K priority index select testbench
// Streams priority vectors into the selector, writes the pick count between
// phases, and predicts the chosen indices with a behavioral argmax model.
// Every output transaction is checked in order against that prediction.
// Both sides of the stream idle in random bursts until the last part of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_priority_index_select_tb;

    localparam int DATA_W          = tkpis_pkg::DATA_W;
    localparam int IDX_W           = tkpis_pkg::IDX_W;
    localparam int CFG_W           = tkpis_pkg::CFG_W;
    localparam int PICK_LIMIT      = tkpis_pkg::PICK_LIMIT;
    localparam int NUM_PICKS_RESET = tkpis_pkg::NUM_PICKS_RESET;
    localparam int SLOTS           = tkpis_pkg::MAX_ENTRIES_DEFAULT + 1;
    localparam int ITEM_TARGET     = 280;
    localparam int SETTLE_CYCLES   = 150;
    localparam int STALL_LIMIT     = 5000;
    localparam int MAX_REPORTS     = 40;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } t_entry;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last_pick;
    } t_pick;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_valid     = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data      = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic               i_s_axis_tlast  = 1'b0;
    logic               i_m_axis_tready = 1'b0;
    logic               o_cfg_ready;
    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [7:0]         o_m_axis_tdata;
    logic               o_m_axis_tlast;

    logic signed [DATA_W-1:0] loaded_values [SLOTS];
    int                       loaded_len    = 0;
    logic [CFG_W-1:0]         picks_setting = CFG_W'(NUM_PICKS_RESET);

    t_entry entry_queue [$];
    t_pick  pending_picks [$];

    int entries_queued   = 0;
    int entries_accepted = 0;
    int vectors_done     = 0;
    int picks_checked    = 0;
    int cfg_writes       = 0;
    int mismatches       = 0;
    int stall_cycles     = 0;
    int src_gap          = 0;
    int sink_gap         = 0;
    bit idling_on        = 1'b1;

    top_k_priority_index_select u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
        end
        mismatches++;
    endtask

    // Stores one entry and, on the final entry, runs the repeated argmax.
    task automatic load_entry(input logic [DATA_W-1:0] value, input logic last);
        int                       picks;
        int                       best;
        bit                       found;
        logic signed [DATA_W-1:0] best_value;
        bit                       taken [SLOTS];
        if (loaded_len < SLOTS) begin
            loaded_values[loaded_len] = value;
            loaded_len++;
        end
        if (last) begin
            picks = (picks_setting > PICK_LIMIT) ? PICK_LIMIT : int'(picks_setting);
            foreach (taken[p]) taken[p] = 1'b0;
            for (int k = 0; k < picks; k++) begin
                best       = 1;
                found      = 1'b0;
                best_value = '0;
                for (int p = 1; p < loaded_len; p++) begin
                    if (!taken[p] && (!found || loaded_values[p] > best_value)) begin
                        found      = 1'b1;
                        best       = p;
                        best_value = loaded_values[p];
                    end
                end
                if (found) taken[best] = 1'b1;
                pending_picks.insert(pending_picks.size(),
                    t_pick'{index: IDX_W'(best), last_pick: (k == picks - 1)});
            end
            loaded_len = 0;
            vectors_done++;
        end
    endtask

    task automatic check_pick(input logic [7:0] tdata, input logic tlast);
        t_pick want;
        if (pending_picks.size() == 0) begin
            report_mismatch("unexpected result, chosen_index", 8'd0, tdata);
        end else begin
            want = pending_picks.pop_front();
            picks_checked++;
            if (tdata !== {1'b0, want.index}) begin
                report_mismatch("chosen_index", {1'b0, want.index}, tdata);
            end
            if (tlast !== want.last_pick) begin
                report_mismatch("final_pick", {7'd0, want.last_pick}, {7'd0, tlast});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_pick(o_m_axis_tdata, o_m_axis_tlast);
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                load_entry(i_s_axis_tdata, i_s_axis_tlast);
                entries_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                picks_setting = i_cfg_data;
                cfg_writes++;
            end
        end
    end

    always @(posedge i_clk) begin : drive_entries
        t_entry head;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (entry_queue.size() != 0) begin
                head = entry_queue.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= head.value;
                i_s_axis_tlast  <= head.last;
                if (idling_on && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(1, 15);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_entry(input logic [DATA_W-1:0] value, input logic last);
        entry_queue.insert(entry_queue.size(), t_entry'{value: value, last: last});
        entries_queued++;
    endtask

    task automatic add_random_vector(input int len);
        int                mode;
        logic [DATA_W-1:0] value;
        mode = $urandom_range(0, 3);
        for (int n = 0; n < len; n++) begin
            case (mode)
                0: value = DATA_W'($urandom_range(0, 3)) - DATA_W'(2);
                1: begin
                    case ($urandom_range(0, 4))
                        0: value = 16'h7FFF;
                        1: value = 16'h8000;
                        2: value = 16'h0000;
                        3: value = 16'hFFFF;
                        default: value = DATA_W'($urandom);
                    endcase
                end
                default: value = DATA_W'($urandom);
            endcase
            add_entry(value, n == len - 1);
        end
    endtask

    function automatic logic [CFG_W-1:0] random_setting();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'(PICK_LIMIT);
            2: return '1;
            3: return CFG_W'($urandom_range(PICK_LIMIT + 1, (1 << CFG_W) - 1));
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic write_picks(input logic [CFG_W-1:0] setting);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= setting;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued entry is accepted and every predicted pick is checked, then settles.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (entries_accepted != entries_queued || pending_picks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the reset pick count the loss slot must be skipped even when largest.
        add_entry(16'h7FFF, 1'b0);
        add_entry(16'hFFFF, 1'b0);
        add_entry(16'h8000, 1'b0);
        add_entry(16'h7FFF, 1'b0);
        add_entry(16'h0000, 1'b1);
        add_entry(16'h1234, 1'b1);
        wait_drained();

        write_picks(CFG_W'(4));
        add_entry(16'd0, 1'b0);
        add_entry(16'd5, 1'b0);
        add_entry(16'd5, 1'b0);
        add_entry(16'h8000, 1'b0);
        add_entry(16'd5, 1'b1);
        wait_drained();

        write_picks('0);
        add_entry(16'h0100, 1'b0);
        add_entry(16'h0200, 1'b1);
        wait_drained();

        write_picks('1);
        add_entry(16'h0300, 1'b0);
        add_entry(16'hF000, 1'b0);
        add_entry(16'h0400, 1'b1);
        wait_drained();

        write_picks(CFG_W'(PICK_LIMIT));
        add_random_vector(SLOTS + 3);
        wait_drained();

        while (entries_queued < ITEM_TARGET) begin
            if (entries_queued > ITEM_TARGET * 4 / 5) idling_on = 1'b0;
            write_picks(random_setting());
            repeat ($urandom_range(2, 5)) begin
                case ($urandom_range(0, 19))
                    0: len = 1;
                    1: len = $urandom_range(20, SLOTS);
                    default: len = $urandom_range(2, 9);
                endcase
                add_random_vector(len);
            end
            wait_drained();
        end

        $display("Run covered %0d vectors, %0d entries, %0d pick-count writes, %0d indices.",
                 vectors_done, entries_accepted, cfg_writes, picks_checked);
        $display("Included ties, extreme values, loss-only, overlong, zero and saturated picks.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/tkpis_pkg.sv
rtl/tkpis_entry_ram.sv
rtl/top_k_priority_index_select.sv
tb/top_k_priority_index_select_tb.sv
